// ===== rtl/ipd_frame_deframer_top_macros.svh =====
// assertion macros used by the deframer parser
`ifndef IPD_FRAME_DEFRAMER_TOP_MACROS_SVH
`define IPD_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ipd_pkg.sv =====
// types, codes and character constants of the deframer
package ipd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COMMA   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

    localparam logic        CMD_BYTE   = 1'b0;
    localparam logic        CMD_TICK   = 1'b1;
    localparam logic        EV_PAYLOAD = 1'b0;
    localparam logic        EV_DONE    = 1'b1;

    localparam logic [15:0] LIMIT_RESET = 16'd10000;
    localparam logic [2:0]  HDR_LAST    = 3'd4;
    localparam logic [2:0]  TAIL_LAST   = 3'd3;

    localparam logic [7:0]  CH_COMMA = 8'h2C;
    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        event_kind;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
        logic        trailer_timed_out;
    } result_t;

    // "+IPD,"
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "OK\r\n"
    function automatic logic [7:0] tail_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h4F;
            2'd1:    c = 8'h4B;
            2'd2:    c = 8'h0D;
            2'd3:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ipd_if.sv =====
// valid/ready channel interfaces for input items and results
interface ipd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface ipd_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        trailer_timed_out;

    modport source (output valid, output event_kind, output payload_byte,
                    output frame_length, output trailer_timed_out, input ready);
    modport sink   (input valid, input event_kind, input payload_byte,
                    input frame_length, input trailer_timed_out, output ready);
endinterface

// ===== rtl/ipd_in_reg.sv =====
// input register stage holding one item until the parser takes it
module ipd_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ipd_pkg::item_t in_item,
    input  logic           drain_ok,
    output logic           step,
    output ipd_pkg::item_t item
);
    import ipd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || drain_ok;
    assign step     = valid_reg && drain_ok;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/ipd_parser.sv =====
// frame state machine: header match, length parse, payload count, trailer wait
module ipd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             step,
    input  ipd_pkg::item_t   item,
    output logic             res_valid,
    output ipd_pkg::result_t result
);
    import ipd_pkg::*;
    `include "ipd_frame_deframer_top_macros.svh"

    phase_t      phase_reg,     phase_next;
    logic [2:0]  match_reg,     match_next;
    logic [15:0] length_reg,    length_next;
    logic        seen_reg,      seen_next;
    logic        closed_reg,    closed_next;
    logic [15:0] remain_reg,    remain_next;
    logic [16:0] count_reg,     count_next;
    logic [15:0] limit_reg;

    logic        is_byte;
    logic [7:0]  b;
    logic [16:0] count_inc;
    logic        counting;
    logic        exceeded;
    logic [15:0] length_mul;
    logic [15:0] remain_dec;
    logic        emit;
    result_t     res;

    assign is_byte    = (item.command == CMD_BYTE);
    assign b          = item.rx_byte;
    assign count_inc  = count_reg + 17'd1;
    assign counting   = (limit_reg != 16'd0);
    assign exceeded   = counting && (count_inc > {1'b0, limit_reg});
    assign length_mul = (length_reg << 3) + (length_reg << 1) + {8'd0, b - CH_ZERO};
    assign remain_dec = remain_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        closed_next = closed_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        res         = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (is_byte)
                begin
                    if (b == hdr_char(match_reg))
                    begin
                        if (match_reg == HDR_LAST)
                        begin
                            phase_next = PH_COMMA;
                            match_next = 3'd0;
                        end
                        else
                        begin
                            match_next = match_reg + 3'd1;
                        end
                    end
                    else if (match_reg > HDR_LAST)
                    begin
                        match_next = 3'd0;
                    end
                end
            end
            PH_COMMA:
            begin
                if (is_byte && b == CH_COMMA)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (is_byte)
                begin
                    if (b == CH_COLON)
                    begin
                        if (length_reg == 16'd0)
                        begin
                            phase_next = PH_TRAILER;
                            match_next = 3'd0;
                            count_next = 17'd0;
                        end
                        else
                        begin
                            remain_next = length_reg;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                    else if (b inside {[CH_ZERO:CH_NINE]})
                    begin
                        if (!closed_reg)
                        begin
                            length_next = length_mul;
                            seen_next   = 1'b1;
                        end
                    end
                    else if (seen_reg)
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (is_byte)
                begin
                    emit             = 1'b1;
                    res.event_kind   = EV_PAYLOAD;
                    res.payload_byte = b;
                    remain_next      = remain_dec;
                    if (remain_dec == 16'd0)
                    begin
                        phase_next = PH_TRAILER;
                        match_next = 3'd0;
                        count_next = 17'd0;
                    end
                end
            end
            PH_TRAILER:
            begin
                if (is_byte && b == tail_char(match_reg[1:0]))
                begin
                    if (match_reg[1:0] == TAIL_LAST[1:0])
                    begin
                        emit             = 1'b1;
                        res.event_kind   = EV_DONE;
                        res.frame_length = length_reg;
                    end
                    else
                    begin
                        match_next = match_reg + 3'd1;
                    end
                end
                else if (counting)
                begin
                    count_next = count_inc;
                    if (exceeded)
                    begin
                        emit                  = 1'b1;
                        res.event_kind        = EV_DONE;
                        res.frame_length      = length_reg;
                        res.trailer_timed_out = 1'b1;
                    end
                end
                if (emit)
                begin
                    phase_next  = PH_HEADER;
                    match_next  = 3'd0;
                    length_next = 16'd0;
                    seen_next   = 1'b0;
                    closed_next = 1'b0;
                    remain_next = 16'd0;
                    count_next  = 17'd0;
                end
            end
            default:
            begin
                if (is_byte)
                begin
                    phase_next  = PH_HEADER;
                    match_next  = 3'd0;
                    length_next = 16'd0;
                    seen_next   = 1'b0;
                    closed_next = 1'b0;
                    remain_next = 16'd0;
                    count_next  = 17'd0;
                end
            end
        endcase
    end

    assign res_valid = step && emit;
    assign result    = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            match_reg  <= 3'd0;
            length_reg <= 16'd0;
            seen_reg   <= 1'b0;
            closed_reg <= 1'b0;
            remain_reg <= 16'd0;
            count_reg  <= 17'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            closed_reg <= closed_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    `IPD_ASSERT_NOW(a_payload_nonzero, clk, rst_n, phase_reg == PH_PAYLOAD,
        remain_reg != 16'd0, "payload phase with no bytes remaining")
    `IPD_ASSERT_NOW(a_header_pos, clk, rst_n, phase_reg == PH_HEADER,
        match_reg <= HDR_LAST, "header match position out of range")
    `IPD_ASSERT_NOW(a_count_idle, clk, rst_n, phase_reg != PH_TRAILER,
        count_reg == 17'd0, "timeout count nonzero outside trailer wait")
    `IPD_ASSERT_NEXT(a_done_clears, clk, rst_n, res_valid && result.event_kind == EV_DONE,
        phase_reg == PH_HEADER && length_reg == 16'd0, "frame end did not clear state")

endmodule

// ===== rtl/ipd_out_reg.sv =====
// result register feeding the output channel
module ipd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ipd_pkg::result_t result,
    output logic             drain_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output ipd_pkg::result_t out_result
);
    import ipd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign drain_ok   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/ipd_frame_deframer_top.sv =====
// path: each input item is held in the input register, and its result is registered in the result register
// throughput: one input item per cycle while the result register is empty or being taken, one result per cycle at most
// both stages advance together whenever the result register is empty or being taken
// reset: asynchronous active-low rst_n empties both stages, returns to header wait
// and loads the trailer timeout limit with 10000
module ipd_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    ipd_in_if.sink      in_ch,
    ipd_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import ipd_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    step;
    logic    drain_ok;
    logic    res_valid;
    result_t result;
    result_t out_result;

    assign in_item.command = in_ch.command;
    assign in_item.rx_byte = in_ch.rx_byte;

    ipd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_item  (in_item),
        .drain_ok (drain_ok),
        .step     (step),
        .item     (item)
    );

    ipd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    ipd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .result     (result),
        .drain_ok   (drain_ok),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_result (out_result)
    );

    assign out_ch.event_kind        = out_result.event_kind;
    assign out_ch.payload_byte      = out_result.payload_byte;
    assign out_ch.frame_length      = out_result.frame_length;
    assign out_ch.trailer_timed_out = out_result.trailer_timed_out;

endmodule

// ===== verif/testbench.sv =====
// testbench for ipd_frame_deframer_top: directed table, then random frames checked by a predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipd_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PHASE_ITEMS = 200;
    localparam int          N_PHASES    = 6;
    localparam int          N_DIRECTED  = 28;
    localparam logic [39:0] HDR_TEXT    = "+IPD,";
    localparam logic [31:0] TAIL_TEXT   = {"OK", 8'h0D, 8'h0A};
    localparam result_t     NO_RES      = '0;
    localparam item_t       TICK_ITEM   = {CMD_TICK, 8'h00};

    typedef struct packed {
        logic    typed;
        item_t   it;
        result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ipd_in_if  in_bus ();
    ipd_out_if out_bus ();

    ipd_frame_deframer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_bus),
        .out_ch    (out_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    phase_t      dfr_phase;
    logic [2:0]  dfr_pos;
    logic [15:0] dfr_length;
    logic        dfr_digit_seen;
    logic        dfr_digits_closed;
    logic [15:0] dfr_remaining;
    logic [16:0] dfr_tail_count;
    logic [15:0] dfr_tail_limit;

    result_t   expected_results [$];
    stim_row_t directed_rows [N_DIRECTED];
    int        failures    = 0;
    int        items_sent  = 0;
    int        cycle_count = 0;
    bit        steady      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_frame();
        dfr_phase         = PH_HEADER;
        dfr_pos           = '0;
        dfr_length        = '0;
        dfr_digit_seen    = 1'b0;
        dfr_digits_closed = 1'b0;
        dfr_remaining     = '0;
        dfr_tail_count    = '0;
    endfunction

    function automatic void open_trailer();
        dfr_phase      = PH_TRAILER;
        dfr_pos        = '0;
        dfr_tail_count = '0;
    endfunction

    function automatic result_t frame_done(input logic timed_out);
        result_t r;
        r                   = NO_RES;
        r.event_kind        = EV_DONE;
        r.frame_length      = dfr_length;
        r.trailer_timed_out = timed_out;
        clear_frame();
        return r;
    endfunction

    function automatic bit deframe_step(input item_t it, output result_t r);
        bit emit;
        emit = 1'b0;
        r    = NO_RES;
        if (dfr_phase == PH_TRAILER)
        begin
            if (it.command == CMD_BYTE && it.rx_byte == TAIL_TEXT[8 * (3 - dfr_pos[1:0]) +: 8])
            begin
                dfr_pos = dfr_pos + 3'd1;
                if (dfr_pos == 3'd4)
                begin
                    r    = frame_done(1'b0);
                    emit = 1'b1;
                end
            end
            else if (dfr_tail_limit != '0)
            begin
                dfr_tail_count = dfr_tail_count + 17'd1;
                if (dfr_tail_count > {1'b0, dfr_tail_limit})
                begin
                    r    = frame_done(1'b1);
                    emit = 1'b1;
                end
            end
        end
        else if (it.command == CMD_BYTE)
        begin
            case (dfr_phase)
                PH_HEADER:
                begin
                    if (it.rx_byte == HDR_TEXT[8 * (4 - dfr_pos) +: 8])
                    begin
                        dfr_pos = dfr_pos + 3'd1;
                        if (dfr_pos == 3'd5)
                        begin
                            dfr_phase = PH_COMMA;
                            dfr_pos   = '0;
                        end
                    end
                end
                PH_COMMA:
                begin
                    if (it.rx_byte == CH_COMMA)
                        dfr_phase = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (it.rx_byte == CH_COLON)
                    begin
                        if (dfr_length == '0)
                            open_trailer();
                        else
                        begin
                            dfr_remaining = dfr_length;
                            dfr_phase     = PH_PAYLOAD;
                        end
                    end
                    else if (it.rx_byte >= CH_ZERO && it.rx_byte <= CH_NINE)
                    begin
                        if (!dfr_digits_closed)
                        begin
                            dfr_length     = dfr_length * 16'd10 + 16'(it.rx_byte - CH_ZERO);
                            dfr_digit_seen = 1'b1;
                        end
                    end
                    else if (dfr_digit_seen)
                        dfr_digits_closed = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    r.event_kind   = EV_PAYLOAD;
                    r.payload_byte = it.rx_byte;
                    emit           = 1'b1;
                    dfr_remaining  = dfr_remaining - 16'd1;
                    if (dfr_remaining == '0)
                        open_trailer();
                end
                default:
                    clear_frame();
            endcase
        end
        return emit;
    endfunction

    function automatic item_t byte_item(input logic [7:0] b);
        item_t it;
        it.command = CMD_BYTE;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.command = ($urandom_range(4) == 0) ? CMD_TICK : CMD_BYTE;
        it.rx_byte = 8'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
        return b;
    endfunction

    // one transfer on the input channel, with a random gap in front
    task automatic offer(input item_t it);
        if (!steady && $urandom_range(99) < 17)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.command <= it.command;
        in_bus.rx_byte <= it.rx_byte;
        do
            @(posedge clk);
        while (!in_bus.ready);
    endtask

    task automatic send_item(input item_t it);
        result_t r;
        if (!(it.command == CMD_TICK && dfr_phase != PH_TRAILER))
            items_sent++;
        offer(it);
        if (deframe_step(it, r))
            expected_results.push_back(r);
    endtask

    task automatic send_frame(input bit hold_trailer);
        int unsigned value;
        int          n_digits;
        logic [7:0]  digits [8];
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(4, 1)) send_item(noise_item());
        for (int k = 0; k < 5; k++)
        begin
            if ($urandom_range(9) == 0)
                send_item(noise_item());
            if ($urandom_range(39) != 0)
                send_item(byte_item(HDR_TEXT[8 * (4 - k) +: 8]));
        end
        if ($urandom_range(7) == 0)
            send_item(noise_item());
        send_item(byte_item(CH_COMMA));

        // length field, sometimes past 16 bits
        value = ($urandom_range(15) == 0) ? 65536 + $urandom_range(6) : $urandom_range(12);
        n_digits = 0;
        do
        begin
            digits[n_digits] = CH_ZERO + 8'(value % 10);
            n_digits++;
            value = value / 10;
        end
        while (value != 0);
        if ($urandom_range(3) == 0)
            send_item(byte_item(non_digit()));
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(3, 1)) send_item(byte_item(CH_ZERO));
        for (int k = n_digits - 1; k >= 0; k--)
            send_item(byte_item(digits[k]));
        if ($urandom_range(4) == 0)
        begin
            send_item(byte_item(non_digit()));
            send_item(byte_item(CH_ZERO + 8'($urandom_range(9))));
        end
        send_item(byte_item(CH_COLON));

        while (dfr_phase == PH_PAYLOAD)
            send_item(($urandom_range(15) == 0) ? noise_item() : byte_item(8'($urandom)));

        if (hold_trailer)
        begin
            repeat (3)
                if (dfr_phase == PH_TRAILER)
                    send_item(TICK_ITEM);
            return;
        end
        if (dfr_tail_limit != '0 && dfr_tail_limit <= 16'd40 && $urandom_range(3) == 0)
            while (dfr_phase == PH_TRAILER)
                send_item(noise_item());
        while (dfr_phase == PH_TRAILER)
        begin
            if ($urandom_range(5) == 0)
                send_item(noise_item());
            if (dfr_phase == PH_TRAILER)
                send_item(byte_item(TAIL_TEXT[8 * (3 - dfr_pos[1:0]) +: 8]));
        end
    endtask

    task automatic settle();
        in_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we         <= 1'b0;
        dfr_tail_limit  = v;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // result side: checking and ready pattern
    initial
    begin
        int      hold_left;
        bit      hold_done;
        result_t got;
        result_t want;
        hold_left = 0;
        hold_done = 1'b0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_bus.valid && out_bus.ready)
            begin
                got = {out_bus.event_kind, out_bus.payload_byte,
                       out_bus.frame_length, out_bus.trailer_timed_out};
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer %p", got);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_kind", want.event_kind, got.event_kind);
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("frame_length", want.frame_length, got.frame_length);
                    check_field("trailer_timed_out", want.trailer_timed_out,
                                got.trailer_timed_out);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else if (!hold_done && items_sent >= PHASE_ITEMS + 60)
            begin
                hold_done = 1'b1;
                hold_left = 400;
                out_bus.ready <= 1'b0;
            end
            else
                out_bus.ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    // input side
    initial
    begin
        result_t     r;
        bit          emit;
        int          phase_end;
        logic [15:0] limits [N_PHASES];
        directed_rows = '{
            {1'b0, CMD_TICK, 8'h00, NO_RES},
            {1'b0, CMD_BYTE, "+", NO_RES},
            {1'b0, CMD_BYTE, "I", NO_RES},
            {1'b0, CMD_BYTE, "P", NO_RES},
            {1'b0, CMD_BYTE, "D", NO_RES},
            {1'b0, CMD_BYTE, ",", NO_RES},
            {1'b0, CMD_BYTE, CH_COMMA, NO_RES},
            {1'b0, CMD_BYTE, 8'h00, NO_RES},
            {1'b0, CMD_BYTE, "2", NO_RES},
            {1'b0, CMD_BYTE, 8'h00, NO_RES},
            {1'b0, CMD_BYTE, "9", NO_RES},
            {1'b0, CMD_BYTE, CH_COLON, NO_RES},
            {1'b1, CMD_BYTE, 8'h00, EV_PAYLOAD, 8'h00, 16'd0, 1'b0},
            {1'b1, CMD_BYTE, 8'hFF, EV_PAYLOAD, 8'hFF, 16'd0, 1'b0},
            {1'b0, CMD_TICK, 8'hFF, NO_RES},
            {1'b0, CMD_BYTE, "O", NO_RES},
            {1'b0, CMD_BYTE, "K", NO_RES},
            {1'b0, CMD_BYTE, 8'h0D, NO_RES},
            {1'b1, CMD_BYTE, 8'h0A, EV_DONE, 8'h00, 16'd2, 1'b0},
            {1'b0, CMD_BYTE, "+", NO_RES},
            {1'b0, CMD_BYTE, "I", NO_RES},
            {1'b0, CMD_BYTE, "P", NO_RES},
            {1'b0, CMD_BYTE, "D", NO_RES},
            {1'b0, CMD_BYTE, ",", NO_RES},
            {1'b0, CMD_BYTE, CH_COMMA, NO_RES},
            {1'b0, CMD_BYTE, CH_COLON, NO_RES},
            {1'b0, CMD_TICK, 8'h00, NO_RES},
            {1'b1, CMD_BYTE, "A", EV_DONE, 8'h00, 16'd0, 1'b1}
        };
        limits = '{LIMIT_RESET, 16'hFFFF, 16'd2, 16'd0, 16'd1, 16'($urandom_range(30, 3))};

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        in_bus.valid   <= 1'b0;
        in_bus.command <= CMD_BYTE;
        in_bus.rx_byte <= '0;
        clear_frame();
        dfr_tail_limit = LIMIT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_limit(16'd1);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            offer(directed_rows[i].it);
            emit = deframe_step(directed_rows[i].it, r);
            if (directed_rows[i].typed)
                expected_results.push_back(directed_rows[i].res);
            else if (emit)
                expected_results.push_back(r);
        end

        // each setting ends with a frame left in its trailer wait, unless its ticks time it out
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            write_limit(limits[p]);
            steady    = (p == 2);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_frame(1'b0);
            send_frame(1'b1);
        end

        settle();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
